// ===== rtl/core/first_fit_heap_allocator_top_assert.svh =====
// Assertion macros for the first-fit heap allocator.
// Expects signals named clk and rst_n in the including module.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ffa_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffa_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int ID_BITS_DEF    = 16;
    // Start-address alignment in units; must be a power of two.
    localparam int ALIGN          = 4;

    localparam int REQ_SIZE_W = 13;
    localparam int ADDR_W     = 32;

    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMEM   = 2'd1,
        STAT_BADFREE = 2'd2
    } status_t;

    typedef struct packed {
        func_t                  func;
        logic [REQ_SIZE_W-1:0]  req_size;
        logic [ADDR_W-1:0]      free_addr;
    } ffa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_addr;
        status_t           status;
    } ffa_res_t;

endpackage

// ===== rtl/core/ffa_owner_ram.sv =====
// Owner-tag store: one write port, one read port, registered read data.
// Uses ffa_pkg for nothing but house consistency of defaults.
module ffa_owner_ram import ffa_pkg::*; #(
    parameter int DEPTH = HEAP_UNITS_DEF,
    parameter int WIDTH = ID_BITS_DEF,
    parameter int AW    = $clog2(HEAP_UNITS_DEF)
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ffa_engine.sv =====
// Allocate/free sequencer: clearing pass, first-fit scan, tagging and release.
// Depends on ffa_pkg and drives an ffa_owner_ram through its ports.
module ffa_engine import ffa_pkg::*; #(
    parameter int HEAP_UNITS = HEAP_UNITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int OFF_W      = $clog2(HEAP_UNITS_DEF)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ADDR_W-1:0]  heap_base,
    input  logic               req_valid,
    output logic               req_ready,
    input  ffa_req_t           req,
    output logic               res_valid,
    input  logic               res_ready,
    output ffa_res_t           res,
    output logic               mem_re,
    output logic [OFF_W-1:0]   mem_raddr,
    input  logic [ID_BITS-1:0] mem_rdata,
    output logic               mem_we,
    output logic [OFF_W-1:0]   mem_waddr,
    output logic [ID_BITS-1:0] mem_wdata
);

`include "first_fit_heap_allocator_top_assert.svh"

    localparam int CNT_W = OFF_W + 1;
    localparam int CMP_W = ((CNT_W > REQ_SIZE_W) ? CNT_W : REQ_SIZE_W) + 1;
    localparam logic [CMP_W-1:0]  LAST_OFF   = CMP_W'(HEAP_UNITS - 1);
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(ALIGN - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_TAG,
        ST_FR_CHK,
        ST_CLR,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      init_ptr_reg, init_ptr_next;
    logic [OFF_W-1:0]      high_mark_reg, high_mark_next;
    logic [ID_BITS-1:0]    next_id_reg, next_id_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [REQ_SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]      limit_reg, limit_next;
    logic [CNT_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      ev_reg, ev_next;
    logic                  pend_reg, pend_next;
    logic [CNT_W-1:0]      run_reg, run_next;
    logic [CNT_W-1:0]      tag_ptr_reg, tag_ptr_next;
    logic [CNT_W-1:0]      hit_end_reg, hit_end_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    status_t               res_status_reg, res_status_next;

    logic [ID_BITS-1:0] id_draw;
    logic [CMP_W-1:0]   limit_sum;
    logic [ADDR_W-1:0]  free_off;
    logic [CNT_W-1:0]   run_new;
    logic [CMP_W-1:0]   start_wide;
    logic [ADDR_W-1:0]  start_abs;
    logic               hit;
    logic [ID_BITS-1:0] cmp_id;
    logic               clr_match;
    logic [CNT_W-1:0]   ev_inc;

    always_comb
    begin
        id_draw = next_id_reg + ID_BITS'(1);
        if (id_draw == '0)
        begin
            id_draw = ID_BITS'(1);
        end
        limit_sum  = CMP_W'(high_mark_reg) + CMP_W'(req.req_size);
        free_off   = req.free_addr - heap_base;
        run_new    = (mem_rdata == '0) ? (run_reg + CNT_W'(1)) : '0;
        start_wide = CMP_W'(ev_reg) + CMP_W'(1) - CMP_W'(size_reg);
        start_abs  = heap_base + ADDR_W'(start_wide);
        hit        = (CMP_W'(run_new) >= CMP_W'(size_reg))
                     && ((start_abs & ALIGN_MASK) == '0);
        cmp_id     = (state_reg == ST_FR_CHK) ? mem_rdata : id_reg;
        clr_match  = (mem_rdata == cmp_id) && (ev_reg <= CNT_W'(high_mark_reg));
        ev_inc     = ev_reg + CNT_W'(1);
    end

    always_comb
    begin
        state_next      = state_reg;
        init_ptr_next   = init_ptr_reg;
        high_mark_next  = high_mark_reg;
        next_id_next    = next_id_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        limit_next      = limit_reg;
        rd_ptr_next     = rd_ptr_reg;
        ev_next         = ev_reg;
        pend_next       = pend_reg;
        run_next        = run_reg;
        tag_ptr_next    = tag_ptr_reg;
        hit_end_next    = hit_end_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_ptr_reg[OFF_W-1:0];
                init_ptr_next = init_ptr_reg + CNT_W'(1);
                if (init_ptr_reg == CNT_W'(HEAP_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_addr_next = '0;
                    if (req.func == FUNC_ALLOC)
                    begin
                        if (req.req_size == '0)
                        begin
                            res_status_next = STAT_NOMEM;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            next_id_next = id_draw;
                            id_next      = id_draw;
                            size_next    = req.req_size;
                            limit_next   = (limit_sum > LAST_OFF) ? CNT_W'(LAST_OFF)
                                                                  : CNT_W'(limit_sum);
                            rd_ptr_next  = '0;
                            ev_next      = '0;
                            run_next     = '0;
                            pend_next    = 1'b0;
                            state_next   = ST_SCAN;
                        end
                    end
                    else if (req.free_addr == '0)
                    begin
                        res_status_next = STAT_OK;
                        state_next      = ST_RESP;
                    end
                    else if (free_off >= ADDR_W'(HEAP_UNITS))
                    begin
                        res_status_next = STAT_BADFREE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        // first read of the unit to free goes out right away
                        mem_re     = 1'b1;
                        mem_raddr  = free_off[OFF_W-1:0];
                        ev_next    = CNT_W'(free_off[OFF_W-1:0]);
                        state_next = ST_FR_CHK;
                    end
                end
            end

            ST_SCAN:
            begin
                // reads run one unit ahead of the evaluated unit
                if (rd_ptr_reg <= limit_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_ptr_reg[OFF_W-1:0];
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    run_next = run_new;
                    ev_next  = ev_inc;
                    if (hit)
                    begin
                        tag_ptr_next  = CNT_W'(start_wide);
                        hit_end_next  = ev_reg;
                        res_addr_next = start_abs;
                        state_next    = ST_TAG;
                    end
                    else if (ev_reg == limit_reg)
                    begin
                        res_addr_next   = '0;
                        res_status_next = STAT_NOMEM;
                        state_next      = ST_RESP;
                    end
                end
            end

            ST_TAG:
            begin
                mem_we       = 1'b1;
                mem_waddr    = tag_ptr_reg[OFF_W-1:0];
                mem_wdata    = id_reg;
                tag_ptr_next = tag_ptr_reg + CNT_W'(1);
                if (tag_ptr_reg == hit_end_reg)
                begin
                    if (hit_end_reg > CNT_W'(high_mark_reg))
                    begin
                        high_mark_next = hit_end_reg[OFF_W-1:0];
                    end
                    res_status_next = STAT_OK;
                    state_next      = ST_RESP;
                end
            end

            ST_FR_CHK, ST_CLR:
            begin
                if ((state_reg == ST_FR_CHK) && (mem_rdata == '0))
                begin
                    res_status_next = STAT_BADFREE;
                    state_next      = ST_RESP;
                end
                else
                begin
                    id_next         = cmp_id;
                    res_status_next = STAT_OK;
                    if (clr_match)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ev_reg[OFF_W-1:0];
                        if (ev_inc <= CNT_W'(high_mark_reg))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = ev_inc[OFF_W-1:0];
                            ev_next    = ev_inc;
                            state_next = ST_CLR;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            init_ptr_reg   <= '0;
            high_mark_reg  <= '0;
            next_id_reg    <= ID_BITS'(1);
            id_reg         <= '0;
            size_reg       <= '0;
            limit_reg      <= '0;
            rd_ptr_reg     <= '0;
            ev_reg         <= '0;
            pend_reg       <= 1'b0;
            run_reg        <= '0;
            tag_ptr_reg    <= '0;
            hit_end_reg    <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            init_ptr_reg   <= init_ptr_next;
            high_mark_reg  <= high_mark_next;
            next_id_reg    <= next_id_next;
            id_reg         <= id_next;
            size_reg       <= size_next;
            limit_reg      <= limit_next;
            rd_ptr_reg     <= rd_ptr_next;
            ev_reg         <= ev_next;
            pend_reg       <= pend_next;
            run_reg        <= run_next;
            tag_ptr_reg    <= tag_ptr_next;
            hit_end_reg    <= hit_end_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
        end
    end

    assign req_ready      = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_RESP);
    assign res.block_addr = res_addr_reg;
    assign res.status     = res_status_reg;

    `FFA_ASSERT_NOW(a_scan_no_write, state_reg == ST_SCAN, !mem_we,
        "owner map written during first-fit scan")
    `FFA_ASSERT_NOW(a_tag_in_range, state_reg == ST_TAG, tag_ptr_reg <= hit_end_reg,
        "tag pointer ran past end of block")
    `FFA_ASSERT_NEXT(a_mark_covers_block,
        state_reg == ST_TAG && tag_ptr_reg == hit_end_reg,
        CNT_W'(high_mark_reg) >= $past(hit_end_reg),
        "high mark below end of new block")
    `FFA_ASSERT_NOW(a_free_addr_zero_ok,
        res_valid && res.status == STAT_BADFREE, res.block_addr == '0,
        "failed free returned nonzero address")

endmodule

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: stream ports, base register, output register.
// Depends on ffa_pkg, ffa_owner_ram and ffa_engine.
//
// One transaction is handled at a time; the owner-tag memory (one read, one write port,
// registered read data) sets the pace. Allocate scans from offset 0 up to at most L, where
// L = min(high mark + size, HEAP_UNITS - 1), then tags the units of the block found;
// free clears the block unit by unit; a zero size, free of address zero or an address
// outside the heap is answered without a memory access. After reset a clearing pass over
// all HEAP_UNITS units runs before the first transaction is accepted. A finished result
// waits in the output register while the next request is taken.
module first_fit_heap_allocator_top import ffa_pkg::*; #(
    parameter int HEAP_UNITS = HEAP_UNITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // heap_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // req_size[12:0], free_addr[44:13], zero fill
    input  logic [0:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // block_addr[31:0], status[33:32], zero fill
);

    localparam int OFF_W = $clog2(HEAP_UNITS);

    logic [ADDR_W-1:0]  heap_base_reg;
    logic               out_valid_reg;
    ffa_res_t           out_res_reg;

    ffa_req_t           req;
    logic               res_valid;
    logic               res_ready;
    ffa_res_t           res;
    logic               mem_re;
    logic [OFF_W-1:0]   mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;
    logic               mem_we;
    logic [OFF_W-1:0]   mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;

    assign req.func      = func_t'(s_axis_tuser[0]);
    assign req.req_size  = s_axis_tdata[12:0];
    assign req.free_addr = s_axis_tdata[44:13];

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                heap_base_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_res_reg.status, out_res_reg.block_addr};

    ffa_owner_ram #(
        .DEPTH (HEAP_UNITS),
        .WIDTH (ID_BITS),
        .AW    (OFF_W)
    ) u_owner_ram (
        .clk   (clk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    ffa_engine #(
        .HEAP_UNITS (HEAP_UNITS),
        .ID_BITS    (ID_BITS),
        .OFF_W      (OFF_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .heap_base (heap_base_reg),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

endmodule

// ===== tb/first_fit_heap_allocator_top_tb.sv =====
// Self-checking testbench for first_fit_heap_allocator_top: owner-tag tracker, stream drivers.
// Depends on ffa_pkg and the allocator RTL; no files or arguments are read.
module first_fit_heap_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int QUIET_LIMIT = 60000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // req_size[12:0], free_addr[44:13], zero fill
    logic [0:0]  s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // block_addr[31:0], status[33:32], zero fill

    // Mirrors the owner map, high mark, id counter and base of the heap.
    class heap_owner_tracker;
        logic [ID_BITS_DEF-1:0] owner_tag [HEAP_UNITS_DEF];
        int unsigned            high_mark;
        logic [ID_BITS_DEF-1:0] last_id;
        logic [ADDR_W-1:0]      heap_base;
        ffa_res_t               awaited_results [$];
        int                     mismatches;
        int                     placed;
        int                     refused;
        int                     freed;
        int                     bad_frees;

        function new();
            foreach (owner_tag[i])
                owner_tag[i] = '0;
            high_mark  = 0;
            last_id    = ID_BITS_DEF'(1);
            heap_base  = '0;
            mismatches = 0;
            placed     = 0;
            refused    = 0;
            freed      = 0;
            bad_frees  = 0;
        endfunction

        function ffa_res_t note_request(ffa_req_t rq);
            ffa_res_t               res;
            logic [ID_BITS_DEF-1:0] id;
            int unsigned            span;
            int unsigned            run;
            int unsigned            start;
            logic [ADDR_W-1:0]      abs_addr;
            logic [ADDR_W-1:0]      off;
            bit                     done;
            res.block_addr = '0;
            res.status     = STAT_OK;
            done           = 1'b0;
            if (rq.func == FUNC_ALLOC)
            begin
                res.status = STAT_NOMEM;
                if (rq.req_size != '0)
                begin
                    // id is drawn even if the scan fails; zero is skipped on wrap
                    last_id = last_id + 1'b1;
                    if (last_id == '0)
                        last_id = ID_BITS_DEF'(1);
                    id   = last_id;
                    span = high_mark + rq.req_size;
                    if (span > HEAP_UNITS_DEF - 1)
                        span = HEAP_UNITS_DEF - 1;
                    run = 0;
                    for (int unsigned i = 0; i <= span && !done; i++)
                    begin
                        if (owner_tag[i] == '0)
                            run++;
                        else
                            run = 0;
                        if (run >= rq.req_size)
                        begin
                            start    = i + 1 - rq.req_size;
                            abs_addr = heap_base + start;
                            if (abs_addr % ADDR_W'(ALIGN) == '0)
                            begin
                                for (int unsigned k = start; k <= i; k++)
                                    owner_tag[k] = id;
                                if (i > high_mark)
                                    high_mark = i;
                                res.block_addr = abs_addr;
                                res.status     = STAT_OK;
                                done           = 1'b1;
                            end
                        end
                    end
                end
                if (res.status == STAT_OK)
                    placed++;
                else
                    refused++;
            end
            else
            begin
                if (rq.free_addr != '0)
                begin
                    off = rq.free_addr - heap_base;
                    if (off >= ADDR_W'(HEAP_UNITS_DEF))
                        res.status = STAT_BADFREE;
                    else if (owner_tag[off] == '0)
                        res.status = STAT_BADFREE;
                    else
                    begin
                        id = owner_tag[off];
                        for (int unsigned i = off;
                             i < HEAP_UNITS_DEF && i <= high_mark && owner_tag[i] == id; i++)
                            owner_tag[i] = '0;
                    end
                end
                if (res.status == STAT_OK)
                    freed++;
                else
                    bad_frees++;
            end
            awaited_results.push_back(res);
            return res;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [39:0] word);
            ffa_res_t want;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result %h with no request outstanding", word));
            else
            begin
                want = awaited_results.pop_front();
                if (word[31:0] != want.block_addr)
                    report_mismatch($sformatf("block_addr %h, expected %h",
                                              word[31:0], want.block_addr));
                if (word[33:32] != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              word[33:32], want.status));
            end
        endtask
    endclass

    heap_owner_tracker tracker = new();
    int unsigned       live_off [$];   // heap offsets of blocks handed out
    int unsigned       live_len [$];
    bit                tx_gaps  = 1'b1;
    bit                rx_gaps  = 1'b1;
    bit                hold_req = 1'b0;

    first_fit_heap_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one request; returns at the edge where it was taken.
    task automatic send_item(input func_t f, input logic [12:0] sz, input logic [31:0] ad);
        ffa_req_t rq;
        ffa_res_t res;
        rq.func      = f;
        rq.req_size  = sz;
        rq.free_addr = ad;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ad, sz};
        s_axis_tuser  <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = tracker.note_request(rq);
        if (f == FUNC_ALLOC && res.status == STAT_OK)
        begin
            live_off.push_back(res.block_addr - tracker.heap_base);
            live_len.push_back(sz);
        end
    endtask

    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic load_heap_base(input logic [31:0] base);
        wait_drained(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.heap_base = base;
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned k;
        int unsigned off;
        logic [31:0] addr;
        logic [12:0] sz;
        pick = $urandom_range(0, 99);
        if (pick < 40 && live_off.size() != 0)
        begin
            k   = $urandom_range(0, live_off.size() - 1);
            off = live_off[k];
            // sometimes start the free inside the block
            if (live_len[k] > 1 && $urandom_range(0, 4) == 0)
                off += $urandom_range(1, live_len[k] - 1);
            live_off.delete(k);
            live_len.delete(k);
            send_item(FUNC_FREE, 13'($urandom), tracker.heap_base + off);
        end
        else if (pick < 50)
        begin
            case ($urandom_range(0, 2))
                0:       addr = tracker.heap_base + $urandom_range(0, HEAP_UNITS_DEF - 1);
                1:       addr = '0;
                default: addr = $urandom;
            endcase
            send_item(FUNC_FREE, 13'($urandom), addr);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                sz = 13'(4 * $urandom_range(1, 8));
            else if (pick < 82)
                sz = 13'($urandom_range(1, 31));
            else if (pick < 94)
                sz = 13'($urandom_range(32, 300));
            else if (pick < 97)
                sz = '0;
            else
                sz = 13'($urandom_range(4096, 8191));
            send_item(FUNC_ALLOC, sz, $urandom);
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, result checking.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("first_fit_heap_allocator_top_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_heap_base(32'h0000_0000);
        send_item(FUNC_ALLOC, 13'd0, $urandom);            // zero size
        send_item(FUNC_ALLOC, 13'd16, $urandom);           // lands at address zero
        send_item(FUNC_FREE, 13'h1fff, 32'h0);             // free of zero does nothing
        send_item(FUNC_ALLOC, 13'd6, $urandom);
        send_item(FUNC_ALLOC, 13'd4, $urandom);            // scan bound too short
        send_item(FUNC_FREE, 13'($urandom), 32'd16);
        send_item(FUNC_FREE, 13'($urandom), 32'd16);       // now untagged
        send_item(FUNC_ALLOC, 13'd8, $urandom);
        send_item(FUNC_ALLOC, 13'd12, $urandom);
        send_item(FUNC_FREE, 13'($urandom), 32'd28);       // starts mid-block
        send_item(FUNC_FREE, 13'($urandom), 32'd100000);   // beyond the store
        send_item(FUNC_FREE, 13'($urandom), 32'hffff_ffff);
        send_item(FUNC_ALLOC, 13'd4096, 32'h0);            // whole store, no room
        send_item(FUNC_ALLOC, 13'h1fff, 32'hffff_ffff);
        send_item(FUNC_ALLOC, 13'd4097, $urandom);

        // all-ones base: offsets wrap through address zero
        load_heap_base(32'hffff_ffff);
        send_item(FUNC_ALLOC, 13'd4, $urandom);
        send_item(FUNC_FREE, 13'($urandom), 32'hffff_ffff); // offset zero block
        send_item(FUNC_ALLOC, 13'd2, $urandom);
        send_item(FUNC_FREE, 13'($urandom), 32'h0);
        send_item(FUNC_FREE, 13'($urandom), 32'hffff_fffe); // below the base

        load_heap_base($urandom);
        repeat (20) random_item();
        // receiver holds off while cheap requests keep coming
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        repeat (6)
        begin
            send_item(FUNC_ALLOC, 13'd0, $urandom);
            send_item(FUNC_FREE, 13'($urandom), 32'h0);
        end
        tx_gaps = 1'b1;
        repeat (20) random_item();

        load_heap_base(32'h8000_0002);
        repeat (40) random_item();

        load_heap_base(32'hffff_fffc);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (30) random_item();

        wait_drained(50);
        $display("%0d requests: %0d blocks placed, %0d allocations refused, %0d frees, %0d bad frees",
                 tracker.placed + tracker.refused + tracker.freed + tracker.bad_frees,
                 tracker.placed, tracker.refused, tracker.freed, tracker.bad_frees);
        $display("bases: zero, all ones, random, misaligned, near top; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (tracker.mismatches == 0)
            $display("first_fit_heap_allocator_top_tb: done, clean");
        else
            $display("first_fit_heap_allocator_top_tb: done, errors");
        $finish;
    end

endmodule
